// ===== rtl/rbsa_pkg.sv =====
// Shared types and constants for the region binned sum aggregator.
package rbsa_pkg;

   localparam int CELL_W  = 32;
   localparam int REG_W   = 5;
   localparam int YEAR_W  = 16;
   localparam int POP_W   = 32;
   localparam int COUNT_W = 32;
   localparam int SUM_W   = 56;
   localparam int REGION_SPACE = 32;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_LOAD = 2'd0;
   localparam mode_type MODE_DATA = 2'd1;
   localparam mode_type MODE_END  = 2'd2;

   typedef struct packed {
      logic accept;
      logic pair_wr;
      logic flush_en;
      logic scan_rd;
      logic year_upd;
   } cmd_type;

   typedef struct packed {
      logic year_diff;
      logic fill_zero;
      logic flush_done;
      logic scan_last;
   } sts_type;

endpackage

// ===== rtl/rbsa_ctrl.sv =====
// Controller state machine: sequences load, flush and table scan.
module rbsa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbsa_pkg::mode_type req_mode,
   input  rbsa_pkg::sts_type  sts,
   output rbsa_pkg::cmd_type  cmd
);
   import rbsa_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FLUSH = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       take;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.accept = 1'b1;
               case (req_mode)
                  MODE_LOAD: cmd.pair_wr = 1'b1;
                  MODE_DATA: begin
                     if (sts.year_diff) begin
                        state_in = S_FLUSH;
                        pend_in  = 1'b1;
                     end else if (!sts.fill_zero) begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_END: begin
                     state_in = S_FLUSH;
                     pend_in  = 1'b0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FLUSH: begin
            cmd.flush_en = 1'b1;
            if (sts.flush_done) begin
               if (pend_ff) begin
                  cmd.year_upd = 1'b1;
                  state_in = sts.fill_zero ? S_IDLE : S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ===== rtl/rbsa_dpath.sv =====
// Datapath: pair table, region bins, flush scan and result register.
module rbsa_dpath #(
   parameter int MAX_PAIRS   = 256,
   parameter int NUM_REGIONS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rbsa_pkg::cmd_type              cmd,
   output rbsa_pkg::sts_type              sts,
   input  logic                           csr_valid,
   input  logic                           csr_raider_split,
   input  logic [rbsa_pkg::CELL_W-1:0]    req_cell_id,
   input  logic [rbsa_pkg::REG_W-1:0]     req_region_in,
   input  logic [rbsa_pkg::YEAR_W-1:0]    req_year_in,
   input  logic [rbsa_pkg::POP_W-1:0]     req_population,
   input  logic                           req_raider_flag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rbsa_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [rbsa_pkg::REG_W-1:0]     rsp_region_out,
   output logic [rbsa_pkg::COUNT_W-1:0]   rsp_cell_count,
   output logic [rbsa_pkg::SUM_W-1:0]     rsp_pop_sum,
   output logic [rbsa_pkg::COUNT_W-1:0]   rsp_raider_count,
   output logic [rbsa_pkg::SUM_W-1:0]     rsp_raider_sum,
   output logic                           rsp_last
);
   import rbsa_pkg::*;

   localparam int NR = (NUM_REGIONS < REGION_SPACE) ? NUM_REGIONS : REGION_SPACE;
   localparam int RW = (NR > 1) ? $clog2(NR) : 1;
   localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int FW = $clog2(MAX_PAIRS + 1);

   logic [CELL_W-1:0]  pair_cells [MAX_PAIRS];
   logic [RW-1:0]      pair_regions [MAX_PAIRS];
   logic [CELL_W-1:0]  rd_cell_ff;
   logic [RW-1:0]      rd_region_ff;
   logic               rd_valid_ff;

   logic [FW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      sidx_ff, sidx_in;
   logic [RW-1:0]      fidx_ff, fidx_in;
   logic [YEAR_W-1:0]  cur_year_ff, cur_year_in;
   logic               sep_ff;

   logic [CELL_W-1:0]  cell_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [POP_W-1:0]   pop_ff;
   logic               raider_ff;

   logic [COUNT_W-1:0] cnt_ff  [NR];
   logic [SUM_W-1:0]   sum_ff  [NR];
   logic [COUNT_W-1:0] rcnt_ff [NR];
   logic [SUM_W-1:0]   rsum_ff [NR];

   logic [NR-1:0]      qual;
   logic               more;
   logic               out_free, emit, adv, pair_ok, hit, to_raider;
   logic [RW-1:0]      upd_idx;
   logic [COUNT_W-1:0] old_cnt, new_cnt;
   logic [SUM_W-1:0]   old_sum, new_sum;
   logic [SUM_W:0]     sum_wide;

   assign out_free = !rsp_valid || rsp_ready;
   assign pair_ok  = (fill_ff != FW'(MAX_PAIRS)) && (32'(req_region_in) < NR);

   always_comb begin
      more = 1'b0;
      for (int r = 0; r < NR; r++) begin
         qual[r] = (cnt_ff[r] != '0) || (sep_ff && (rcnt_ff[r] != '0));
         if ((r > int'(fidx_ff)) && qual[r]) more = 1'b1;
      end
   end

   assign emit = cmd.flush_en && qual[fidx_ff] && out_free;
   assign adv  = cmd.flush_en && (!qual[fidx_ff] || out_free);

   assign sts.year_diff  = (req_year_in != cur_year_ff);
   assign sts.fill_zero  = (fill_ff == '0);
   assign sts.flush_done = adv && (fidx_ff == RW'(NR - 1));
   assign sts.scan_last  = ((FW'(sidx_ff) + FW'(1)) == fill_ff);

   assign fill_in     = (cmd.pair_wr && pair_ok) ? fill_ff + FW'(1) : fill_ff;
   assign sidx_in     = cmd.scan_rd ? sidx_ff + AW'(1) : '0;
   assign fidx_in     = cmd.flush_en ? (adv ? fidx_ff + RW'(1) : fidx_ff) : '0;
   assign cur_year_in = cmd.year_upd ? year_ff : cur_year_ff;

   assign hit       = rd_valid_ff && (rd_cell_ff == cell_ff);
   assign to_raider = sep_ff && raider_ff;
   assign upd_idx   = rd_region_ff;
   assign old_cnt   = to_raider ? rcnt_ff[upd_idx] : cnt_ff[upd_idx];
   assign old_sum   = to_raider ? rsum_ff[upd_idx] : sum_ff[upd_idx];
   assign new_cnt   = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_W'(1);
   assign sum_wide  = {1'b0, old_sum} + (SUM_W + 1)'(pop_ff);
   assign new_sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.pair_wr && pair_ok) begin
         pair_cells[fill_ff[AW-1:0]]   <= req_cell_id;
         pair_regions[fill_ff[AW-1:0]] <= req_region_in[RW-1:0];
      end
      rd_cell_ff   <= pair_cells[sidx_ff];
      rd_region_ff <= pair_regions[sidx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cell_ff   <= req_cell_id;
         year_ff   <= req_year_in;
         pop_ff    <= req_population;
         raider_ff <= req_raider_flag;
      end
      if (emit) begin
         rsp_year_out     <= cur_year_ff;
         rsp_region_out   <= REG_W'(fidx_ff);
         rsp_cell_count   <= cnt_ff[fidx_ff];
         rsp_pop_sum      <= sum_ff[fidx_ff];
         rsp_raider_count <= sep_ff ? rcnt_ff[fidx_ff] : '0;
         rsp_raider_sum   <= sep_ff ? rsum_ff[fidx_ff] : '0;
         rsp_last         <= !more;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         sidx_ff     <= '0;
         fidx_ff     <= '0;
         cur_year_ff <= '0;
         sep_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
         for (int r = 0; r < NR; r++) begin
            cnt_ff[r]  <= '0;
            sum_ff[r]  <= '0;
            rcnt_ff[r] <= '0;
            rsum_ff[r] <= '0;
         end
      end else begin
         fill_ff     <= fill_in;
         sidx_ff     <= sidx_in;
         fidx_ff     <= fidx_in;
         cur_year_ff <= cur_year_in;
         rd_valid_ff <= cmd.scan_rd;
         if (csr_valid) sep_ff <= csr_raider_split;
         if (emit) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
         if (emit) begin
            cnt_ff[fidx_ff] <= '0;
            sum_ff[fidx_ff] <= '0;
            if (sep_ff) begin
               rcnt_ff[fidx_ff] <= '0;
               rsum_ff[fidx_ff] <= '0;
            end
         end else if (hit) begin
            if (to_raider) begin
               rcnt_ff[upd_idx] <= new_cnt;
               rsum_ff[upd_idx] <= new_sum;
            end else begin
               cnt_ff[upd_idx] <= new_cnt;
               sum_ff[upd_idx] <= new_sum;
            end
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_PAIRS)) else $error("pair fill beyond capacity");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("result overwritten");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.flush_en && rd_valid_ff)) else $error("flush during bin update");
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> (cnt_ff[$past(fidx_ff)] == '0)) else $error("bin not cleared");

endmodule

// ===== rtl/region_binned_sum_aggregator.sv =====
// Top level of the region binned sum aggregator.
//  port group   direction  carries
//  req_*        in         load pair, data record or end flush request
//  rsp_*        out        one flushed region per result, last marks end
//  csr_*        in         raider split register write
// A load or a same-year record with no pairs is done without leaving the controller's idle state.
// A data record scans the whole pair table, one entry a cycle.
// A flush walks all regions, one per cycle, plus stalls on rsp_ready.
// Reset clears fill, year, bins and the register at once; no clearing pass.
// req_ready is low while a flush or scan runs; a stalled result holds the walk.
module region_binned_sum_aggregator #(
   parameter int MAX_PAIRS   = 256,
   parameter int NUM_REGIONS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rbsa_pkg::mode_type             req_mode,
   input  logic [rbsa_pkg::CELL_W-1:0]    req_cell_id,
   input  logic [rbsa_pkg::REG_W-1:0]     req_region_in,
   input  logic [rbsa_pkg::YEAR_W-1:0]    req_year_in,
   input  logic [rbsa_pkg::POP_W-1:0]     req_population,
   input  logic                           req_raider_flag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rbsa_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [rbsa_pkg::REG_W-1:0]     rsp_region_out,
   output logic [rbsa_pkg::COUNT_W-1:0]   rsp_cell_count,
   output logic [rbsa_pkg::SUM_W-1:0]     rsp_pop_sum,
   output logic [rbsa_pkg::COUNT_W-1:0]   rsp_raider_count,
   output logic [rbsa_pkg::SUM_W-1:0]     rsp_raider_sum,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_raider_split
);
   import rbsa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rbsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbsa_dpath #(
      .MAX_PAIRS   (MAX_PAIRS),
      .NUM_REGIONS (NUM_REGIONS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_valid            (csr_valid),
      .csr_raider_split     (csr_raider_split),
      .req_cell_id          (req_cell_id),
      .req_region_in        (req_region_in),
      .req_year_in          (req_year_in),
      .req_population       (req_population),
      .req_raider_flag      (req_raider_flag),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_year_out         (rsp_year_out),
      .rsp_region_out       (rsp_region_out),
      .rsp_cell_count       (rsp_cell_count),
      .rsp_pop_sum          (rsp_pop_sum),
      .rsp_raider_count     (rsp_raider_count),
      .rsp_raider_sum       (rsp_raider_sum),
      .rsp_last             (rsp_last)
   );

endmodule

// ===== tb/region_binned_sum_aggregator_tb.sv =====
// Self-checking testbench for the region binned sum aggregator.
typedef struct {
   logic [15:0] year;
   logic [4:0]  region;
   logic [31:0] count;
   logic [55:0] sum;
   logic [31:0] rcount;
   logic [55:0] rsum;
   logic        last;
} region_total_type;

class region_totals_board;
   localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
   localparam logic [55:0] SUM_TOP   = 56'hFF_FFFF_FFFF_FFFF;
   localparam int MAX_PAIRS   = 256;
   localparam int NUM_REGIONS = 32;

   logic [31:0] pair_cell [MAX_PAIRS];
   logic [4:0]  pair_region [MAX_PAIRS];
   int          pair_count;
   logic [15:0] year_now;
   logic [31:0] count_bin [32];
   logic [55:0] sum_bin [32];
   logic [31:0] rcount_bin [32];
   logic [55:0] rsum_bin [32];
   logic        split_raiders;
   region_total_type totals_due [$];
   int mismatches;
   int checked;
   int flushes;

   function new();
      pair_count = 0;
      year_now = 0;
      split_raiders = 0;
      mismatches = 0;
      checked = 0;
      flushes = 0;
      for (int r = 0; r < 32; r++) begin
         count_bin[r] = 0;
         sum_bin[r] = 0;
         rcount_bin[r] = 0;
         rsum_bin[r] = 0;
      end
   endfunction

   function logic [31:0] count_inc(logic [31:0] c);
      return (c == COUNT_TOP) ? COUNT_TOP : c + 32'd1;
   endfunction

   function logic [55:0] sum_add(logic [55:0] s, logic [31:0] v);
      logic [56:0] t;
      t = {1'b0, s} + {25'd0, v};
      return (t > {1'b0, SUM_TOP}) ? SUM_TOP : t[55:0];
   endfunction

   function void emit_totals();
      region_total_type t;
      int n;
      n = 0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
         if (count_bin[r] == 0 && !(split_raiders && rcount_bin[r] != 0))
            continue;
         t.year = year_now;
         t.region = 5'(r);
         t.count = count_bin[r];
         t.sum = sum_bin[r];
         t.rcount = split_raiders ? rcount_bin[r] : 32'd0;
         t.rsum = split_raiders ? rsum_bin[r] : 56'd0;
         t.last = 1'b0;
         if (split_raiders) begin
            rcount_bin[r] = 0;
            rsum_bin[r] = 0;
         end
         count_bin[r] = 0;
         sum_bin[r] = 0;
         totals_due = {totals_due, t};
         n++;
      end
      if (n > 0) begin
         totals_due[$].last = 1'b1;
         flushes++;
      end
   endfunction

   function void note_request(rbsa_pkg::mode_type mode, logic [31:0] cell_id,
                              logic [4:0] region, logic [15:0] year,
                              logic [31:0] pop, logic raider);
      if (mode == rbsa_pkg::MODE_LOAD) begin
         if (pair_count < MAX_PAIRS && region < NUM_REGIONS) begin
            pair_cell[pair_count] = cell_id;
            pair_region[pair_count] = region;
            pair_count++;
         end
      end else if (mode == rbsa_pkg::MODE_END) begin
         emit_totals();
      end else if (mode == rbsa_pkg::MODE_DATA) begin
         if (year != year_now) begin
            emit_totals();
            year_now = year;
         end
         for (int i = 0; i < pair_count; i++) begin
            if (pair_cell[i] != cell_id)
               continue;
            if (split_raiders && raider) begin
               rcount_bin[pair_region[i]] = count_inc(rcount_bin[pair_region[i]]);
               rsum_bin[pair_region[i]] = sum_add(rsum_bin[pair_region[i]], pop);
            end else begin
               count_bin[pair_region[i]] = count_inc(count_bin[pair_region[i]]);
               sum_bin[pair_region[i]] = sum_add(sum_bin[pair_region[i]], pop);
            end
         end
      end
   endfunction

   function void check_total(region_total_type got);
      region_total_type want;
      checked++;
      if (totals_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: region %0d year %0d", got.region, got.year);
         return;
      end
      want = totals_due.pop_front();
      if (got.year !== want.year || got.region !== want.region ||
          got.count !== want.count || got.sum !== want.sum ||
          got.rcount !== want.rcount || got.rsum !== want.rsum ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch exp: yr %0d rg %0d cnt %0d sum %0d rcnt %0d rsum %0d last %0b",
                     want.year, want.region, want.count, want.sum, want.rcount,
                     want.rsum, want.last);
            $display("         got: yr %0d rg %0d cnt %0d sum %0d rcnt %0d rsum %0d last %0b",
                     got.year, got.region, got.count, got.sum, got.rcount,
                     got.rsum, got.last);
         end
      end
   endfunction
endclass

module region_binned_sum_aggregator_tb;
   import rbsa_pkg::*;

   localparam mode_type MODE_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE = 400;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   mode_type req_mode = MODE_LOAD;
   logic [31:0] req_cell_id = 0;
   logic [4:0]  req_region_in = 0;
   logic [15:0] req_year_in = 0;
   logic [31:0] req_population = 0;
   logic req_raider_flag = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [15:0] rsp_year_out;
   logic [4:0]  rsp_region_out;
   logic [31:0] rsp_cell_count;
   logic [55:0] rsp_pop_sum;
   logic [31:0] rsp_raider_count;
   logic [55:0] rsp_raider_sum;
   logic rsp_last;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_raider_split = 0;

   region_totals_board board = new();
   int cycles = 0;
   int requests = 0;
   int burst_left = 0;
   bit hold_go = 0;
   logic [31:0] cell_pool [16];
   logic [15:0] year_cur = 0;

   region_binned_sum_aggregator uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      region_total_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.year = rsp_year_out;
         got.region = rsp_region_out;
         got.count = rsp_cell_count;
         got.sum = rsp_pop_sum;
         got.rcount = rsp_raider_count;
         got.rsum = rsp_raider_sum;
         got.last = rsp_last;
         board.check_total(got);
      end
   end

   // receiver stall pattern; long hold on demand
   initial begin
      int stretch;
      int style;
      forever begin
         if (hold_go) begin
            rsp_ready <= 0;
            repeat (1500) @(posedge clock);
            hold_go = 0;
         end
         style = $urandom_range(0, 2);
         stretch = $urandom_range(5, 60);
         repeat (stretch) begin
            @(posedge clock);
            case (style)
               0: rsp_ready <= 1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task send_req(mode_type mode, logic [31:0] cell_id, logic [4:0] region,
                 logic [15:0] year, logic [31:0] pop, logic raider);
      int gap;
      req_valid <= 1;
      req_mode <= mode;
      req_cell_id <= cell_id;
      req_region_in <= region;
      req_year_in <= year;
      req_population <= pop;
      req_raider_flag <= raider;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(mode, cell_id, region, year, pop, raider);
      requests++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.totals_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_split(logic value);
      drain();
      csr_valid <= 1;
      csr_raider_split <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.split_raiders = value;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task load_pair(logic [31:0] cell_id, logic [4:0] region);
      send_req(MODE_LOAD, cell_id, region, 16'($urandom), $urandom,
               1'($urandom_range(0, 1)));
   endtask

   task record(logic [31:0] cell_id, logic [15:0] year, logic [31:0] pop, logic raider);
      send_req(MODE_DATA, cell_id, 5'($urandom), year, pop, raider);
   endtask

   task end_flush();
      send_req(MODE_END, $urandom, 5'($urandom), 16'($urandom), $urandom,
               1'($urandom_range(0, 1)));
   endtask

   task random_item();
      int pick;
      logic [31:0] pop;
      pick = $urandom_range(0, 99);
      pop = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
      if ($urandom_range(0, 9) == 0)
         year_cur = ($urandom_range(0, 5) == 0) ? 16'($urandom) : year_cur + 16'd1;
      if (pick < 8)
         load_pair(cell_pool[$urandom_range(0, 15)], 5'($urandom));
      else if (pick < 78)
         record(cell_pool[$urandom_range(0, 15)], year_cur, pop,
                1'($urandom_range(0, 1)));
      else if (pick < 86)
         record($urandom, year_cur, pop, 1'($urandom_range(0, 1)));
      else if (pick < 94)
         end_flush();
      else
         send_req(MODE_NONE, $urandom, 5'($urandom), 16'($urandom), $urandom,
                  1'($urandom_range(0, 1)));
   endtask

   initial begin
      for (int i = 0; i < 16; i++)
         cell_pool[i] = $urandom;
      cell_pool[0] = 32'h0000_0000;
      cell_pool[1] = 32'hFFFF_FFFF;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_split(0);

      // directed: multi-region cells, duplicate pair, unknown cell, year steps
      load_pair(32'h0000_0000, 5'd0);
      load_pair(32'hFFFF_FFFF, 5'd31);
      load_pair(32'h0000_0000, 5'd31);
      load_pair(32'hFFFF_FFFF, 5'd31);
      load_pair(32'hA5A5_5A5A, 5'd10);
      end_flush();
      send_req(MODE_NONE, 32'h0000_0000, 5'd0, 16'd7, 32'd9, 1'b1);
      record(32'h0000_0000, 16'd0, 32'hFFFF_FFFF, 1'b1);
      record(32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF, 1'b0);
      record(32'h1234_5678, 16'd0, 32'd55, 1'b0);
      record(32'hA5A5_5A5A, 16'd1, 32'd0, 1'b0);
      record(32'h1234_5678, 16'hFFFF, 32'd3, 1'b0);
      record(32'h0000_0000, 16'hFFFF, 32'd1, 1'b0);
      end_flush();
      end_flush();
      write_split(1);
      record(32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      record(32'hFFFF_FFFF, 16'hFFFF, 32'd17, 1'b1);
      record(32'hA5A5_5A5A, 16'hFFFF, 32'd4, 1'b0);
      record(32'h0000_0000, 16'd0, 32'd2, 1'b1);
      end_flush();
      year_cur = 16'd0;

      for (int phase = 0; phase < 5; phase++) begin
         write_split(phase % 2 == 0);
         for (int k = 0; k < 4; k++)
            load_pair(cell_pool[$urandom_range(0, 15)], 5'($urandom));
         if (phase == 1)
            hold_go = 1;
         if (phase == 4) begin
            // overfill the table; later loads are dropped
            while (board.pair_count < 256)
               load_pair(cell_pool[$urandom_range(0, 15)], 5'($urandom));
            for (int k = 0; k < 6; k++)
               load_pair(cell_pool[$urandom_range(0, 15)], 5'($urandom));
         end
         for (int k = 0; k < 20; k++)
            random_item();
         end_flush();
      end
      drain();

      $display("%0d requests, %0d results in %0d flushes, %0d pairs loaded, %0d cycles",
               requests, board.checked, board.flushes, board.pair_count, cycles);
      $display("covered: both raider settings, year changes, unknown cells, full table");
      if (board.mismatches == 0 && board.totals_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.totals_due.size());
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rbsa_pkg.sv
rtl/rbsa_ctrl.sv
rtl/rbsa_dpath.sv
rtl/region_binned_sum_aggregator.sv
tb/region_binned_sum_aggregator_tb.sv
